@@ hdl/octave_gradient_noise_3d_assert.svh @@
// Assertion macros shared by the checker files.
`ifndef OCTAVE_GRADIENT_NOISE_3D_ASSERT_SVH
`define OCTAVE_GRADIENT_NOISE_3D_ASSERT_SVH

// Antecedent implies consequent in the next cycle, off while reset is high.
`define OGN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same, but also checked while reset is high.
`define OGN_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ogn3d_pkg.sv @@
package ogn3d_pkg;

   // Octave counter width, enough for up to 16 octaves
   localparam int OCT_W = 5;
   // Amplitude 1.0 in Q.14
   localparam logic [31:0] AMP_ONE = 32'd16384;

   // Register indexes of the configuration port
   localparam logic CSR_OCTAVE_COUNT = 1'b0;
   localparam logic CSR_PERSISTENCE  = 1'b1;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_F1, OP_F2, OP_F3, OP_F4, OP_F5,
      OP_H1, OP_H2, OP_H3, OP_GRAD,
      OP_L1, OP_L2,
      OP_ACC_MUL, OP_ACC_ADD, OP_AMP,
      OP_DIV_INIT, OP_DIV_STEP,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FADE, ST_HASH, ST_LERP, ST_ACC, ST_DIVIDE, ST_FINISH
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;    // fade axis: 0 x, 1 y, 2 z
      logic [2:0] corner;  // cube corner: bit0 x, bit1 y, bit2 z
      logic [2:0] lstep;   // interpolation step 0..6
   } cmd_type;

   typedef struct packed {
      logic total_pos;     // weighted total above zero
   } status_type;

   localparam logic [7:0] PERM_TABLE [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
      8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
      8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
      8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
      8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
      8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
      8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
      8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
      8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
      8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
      8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
      8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
      8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
      8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
      8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
      8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
      8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
      8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
      8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

endpackage

@@ hdl/ogn3d_ctrl.sv @@
module ogn3d_ctrl #(
   parameter int MAX_OCTAVES = 8,
   parameter int DIV_STEPS   = 55
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   out_free,
   input  logic [3:0]             octave_count,
   input  ogn3d_pkg::status_type  status,
   output ogn3d_pkg::cmd_type     cmd
);
   import ogn3d_pkg::*;

   localparam int IW = $clog2(DIV_STEPS + 1);

   state_type        state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [2:0]       sub_ff, sub_in;
   logic [OCT_W-1:0] oct_ff, oct_in;
   logic [OCT_W-1:0] oct_req, oct_eff;
   logic             last_oct;

   // Octaves to run: zero means one, clamp at the maximum
   always_comb begin
      oct_req = OCT_W'(octave_count);
      if (oct_req == '0) begin
         oct_eff = OCT_W'(1);
      end else if (oct_req > OCT_W'(MAX_OCTAVES)) begin
         oct_eff = OCT_W'(MAX_OCTAVES);
      end else begin
         oct_eff = oct_req;
      end
      last_oct = (OCT_W'(oct_ff + 1'b1) == oct_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         sub_ff   <= '0;
         oct_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         sub_ff   <= sub_in;
         oct_ff   <= oct_in;
      end
   end

   // Sequencer: fade, hash, lerp and accumulate per octave, then divide when the total is positive
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      sub_in     = sub_ff;
      oct_in     = oct_ff;
      req_ready  = 1'b0;
      cmd.op     = OP_NOP;
      cmd.axis   = idx_ff[1:0];
      cmd.corner = idx_ff[2:0];
      cmd.lstep  = idx_ff[2:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_FADE;
               idx_in   = '0;
               sub_in   = '0;
               oct_in   = '0;
            end
         end
         ST_FADE: begin
            unique case (sub_ff)
               3'd0:    cmd.op = OP_F1;
               3'd1:    cmd.op = OP_F2;
               3'd2:    cmd.op = OP_F3;
               3'd3:    cmd.op = OP_F4;
               default: cmd.op = OP_F5;
            endcase
            if (sub_ff == 3'd4) begin
               sub_in = '0;
               if (idx_ff == IW'(2)) begin
                  idx_in   = '0;
                  state_in = ST_HASH;
               end else begin
                  idx_in = IW'(idx_ff + 1'b1);
               end
            end else begin
               sub_in = 3'(sub_ff + 1'b1);
            end
         end
         ST_HASH: begin
            unique case (sub_ff)
               3'd0:    cmd.op = OP_H1;
               3'd1:    cmd.op = OP_H2;
               3'd2:    cmd.op = OP_H3;
               default: cmd.op = OP_GRAD;
            endcase
            if (sub_ff == 3'd3) begin
               sub_in = '0;
               if (idx_ff == IW'(7)) begin
                  idx_in   = '0;
                  state_in = ST_LERP;
               end else begin
                  idx_in = IW'(idx_ff + 1'b1);
               end
            end else begin
               sub_in = 3'(sub_ff + 1'b1);
            end
         end
         ST_LERP: begin
            if (sub_ff == 3'd0) begin
               cmd.op = OP_L1;
               sub_in = 3'd1;
            end else begin
               cmd.op = OP_L2;
               sub_in = '0;
               if (idx_ff == IW'(6)) begin
                  idx_in   = '0;
                  state_in = ST_ACC;
               end else begin
                  idx_in = IW'(idx_ff + 1'b1);
               end
            end
         end
         ST_ACC: begin
            unique case (sub_ff)
               3'd0:    cmd.op = OP_ACC_MUL;
               3'd1:    cmd.op = OP_ACC_ADD;
               default: cmd.op = OP_AMP;
            endcase
            if (sub_ff == 3'd2) begin
               sub_in = '0;
               idx_in = '0;
               if (!last_oct) begin
                  oct_in   = OCT_W'(oct_ff + 1'b1);
                  state_in = ST_FADE;
               end else if (status.total_pos) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               sub_in = 3'(sub_ff + 1'b1);
            end
         end
         ST_DIVIDE: begin
            cmd.op = (idx_ff == '0) ? OP_DIV_INIT : OP_DIV_STEP;
            if (idx_ff == IW'(DIV_STEPS)) begin
               idx_in   = '0;
               state_in = ST_FINISH;
            end else begin
               idx_in = IW'(idx_ff + 1'b1);
            end
         end
         default: begin
            if (out_free) begin
               cmd.op   = OP_DONE;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

endmodule

@@ hdl/ogn3d_dp.sv @@
module ogn3d_dp #(
   parameter int FRAC_BITS   = 16,
   parameter int MAX_OCTAVES = 8,
   parameter int TOTAL_W     = 55
) (
   input  logic                   clock,
   input  ogn3d_pkg::cmd_type     cmd,
   input  logic [23:0]            coord_x,
   input  logic [23:0]            coord_y,
   input  logic [23:0]            coord_z,
   input  logic [15:0]            persistence,
   output ogn3d_pkg::status_type  status,
   output logic [15:0]            noise_value
);
   import ogn3d_pkg::*;

   localparam int CW  = 8 + FRAC_BITS;          // coordinate width
   localparam int MW  = FRAC_BITS + 5;          // multiplier operand width
   localparam int PW  = 2 * MW;                 // product width
   localparam int GW  = FRAC_BITS + 2;          // gradient / lerp value width
   localparam int P2W = GW + 34;                // octave value times amplitude
   localparam int AW  = 32 + $clog2(MAX_OCTAVES);
   localparam int TW  = TOTAL_W;
   localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic signed [MW-1:0] ONE_M   = MW'(1) <<< FRAC_BITS;
   localparam logic signed [MW-1:0] ONE15_M = (ONE_M <<< 4) - ONE_M;
   localparam logic signed [MW-1:0] ONE10_M = (ONE_M <<< 3) + (ONE_M <<< 1);
   localparam logic signed [GW-1:0] ONE_G   = GW'(1) <<< FRAC_BITS;

   logic [CW-1:0]           cx_ff, cy_ff, cz_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [MW-1:0]    inner_ff;
   logic [FRAC_BITS:0]      fade_ff [3];
   logic [7:0]              hash_ff;
   logic signed [GW-1:0]    val_ff [8];
   logic signed [P2W-1:0]   prod2_ff;
   logic [47:0]             ampm_ff;
   logic [31:0]             amp_ff;
   logic [AW-1:0]           ampsum_ff;
   logic signed [TW-1:0]    total_ff;
   logic [AW:0]             rem_ff;
   logic [TW-1:0]           quo_ff;

   logic [CW+23:0]          ldx, ldy, ldz;
   logic [FRAC_BITS-1:0]    fsel;
   logic signed [MW-1:0]    fz, prod_hi, mul_a, mul_b;
   logic [7:0]              xc, yc, zc, hidx;
   logic signed [GW-1:0]    gx, gy, gz, grad;
   logic signed [GW-1:0]    la, lb;
   logic [FRAC_BITS:0]      lu;
   logic [2:0]              ldst;
   logic signed [GW:0]      ldiff, pw;
   logic signed [MW-1:0]    lsum;
   logic [33:0]             amp_sh;
   logic [AW:0]             remt;
   logic [TW+15:0]          qw, qs;

   assign prod_hi = prod_ff[FRAC_BITS +: MW];
   assign ldx = (CW + 24)'(coord_x);
   assign ldy = (CW + 24)'(coord_y);
   assign ldz = (CW + 24)'(coord_z);

   // Fraction of the selected axis
   always_comb begin
      unique case (cmd.axis)
         2'd0:    fsel = cx_ff[FRAC_BITS-1:0];
         2'd1:    fsel = cy_ff[FRAC_BITS-1:0];
         default: fsel = cz_ff[FRAC_BITS-1:0];
      endcase
      fz = MW'(fsel);
   end

   // Corner lattice indexes and gradient inputs
   always_comb begin
      xc = 8'(cx_ff[FRAC_BITS +: 8] + cmd.corner[0]);
      yc = 8'(cy_ff[FRAC_BITS +: 8] + cmd.corner[1]);
      zc = 8'(cz_ff[FRAC_BITS +: 8] + cmd.corner[2]);
      gx = GW'(cx_ff[FRAC_BITS-1:0]) - (cmd.corner[0] ? ONE_G : GW'(0));
      gy = GW'(cy_ff[FRAC_BITS-1:0]) - (cmd.corner[1] ? ONE_G : GW'(0));
      gz = GW'(cz_ff[FRAC_BITS-1:0]) - (cmd.corner[2] ? ONE_G : GW'(0));
      unique case (cmd.op)
         OP_H2:   hidx = 8'(hash_ff + yc);
         OP_H3:   hidx = 8'(hash_ff + zc);
         default: hidx = xc;
      endcase
   end

   // Gradient picked by the low hash nibble
   always_comb begin
      unique case (hash_ff[3:0])
         4'd0:    grad = gx + gy;
         4'd1:    grad = gy - gx;
         4'd2:    grad = gx - gy;
         4'd3:    grad = -gx - gy;
         4'd4:    grad = gx + gz;
         4'd5:    grad = gz - gx;
         4'd6:    grad = gx - gz;
         4'd7:    grad = -gx - gz;
         4'd8:    grad = gy + gz;
         4'd9:    grad = gz - gy;
         4'd10:   grad = gy - gz;
         4'd11:   grad = -gy - gz;
         4'd12:   grad = gy + gx;
         4'd13:   grad = gz - gy;
         4'd14:   grad = gy - gx;
         default: grad = -gy - gz;
      endcase
   end

   // Trilinear tree: x pairs, then y, then z
   always_comb begin
      unique case (cmd.lstep)
         3'd0: begin la = val_ff[0]; lb = val_ff[1]; lu = fade_ff[0]; ldst = 3'd0; end
         3'd1: begin la = val_ff[2]; lb = val_ff[3]; lu = fade_ff[0]; ldst = 3'd2; end
         3'd2: begin la = val_ff[0]; lb = val_ff[2]; lu = fade_ff[1]; ldst = 3'd0; end
         3'd3: begin la = val_ff[4]; lb = val_ff[5]; lu = fade_ff[0]; ldst = 3'd4; end
         3'd4: begin la = val_ff[6]; lb = val_ff[7]; lu = fade_ff[0]; ldst = 3'd6; end
         3'd5: begin la = val_ff[4]; lb = val_ff[6]; lu = fade_ff[1]; ldst = 3'd4; end
         default: begin
            la = val_ff[0]; lb = val_ff[4]; lu = fade_ff[2]; ldst = 3'd0;
         end
      endcase
      ldiff = (GW + 1)'(lb) - (GW + 1)'(la);
      lsum  = MW'(la) + prod_hi;
   end

   // Shared multiplier operand select
   always_comb begin
      unique case (cmd.op)
         OP_F1: begin mul_a = fz; mul_b = ONE15_M - ((fz <<< 2) + (fz <<< 1)); end
         OP_F2: begin mul_a = fz; mul_b = fz; end
         OP_F3: begin mul_a = prod_hi; mul_b = fz; end
         OP_F4: begin mul_a = prod_hi; mul_b = inner_ff; end
         OP_L1: begin mul_a = MW'(lu); mul_b = MW'(ldiff); end
         default: begin mul_a = prod_hi; mul_b = inner_ff; end
      endcase
   end

   // Octave value (n + 1) / 2 and next amplitude
   always_comb begin
      pw     = ((GW + 1)'(val_ff[0]) + (GW + 1)'(ONE_G)) >>> 1;
      amp_sh = ampm_ff[47:14];
      remt   = {rem_ff[AW-1:0], quo_ff[TW-1]};
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (cmd.op)
         OP_LOAD: begin
            cx_ff     <= ldx[CW-1:0];
            cy_ff     <= ldy[CW-1:0];
            cz_ff     <= ldz[CW-1:0];
            total_ff  <= '0;
            ampsum_ff <= '0;
            amp_ff    <= AMP_ONE;
         end
         OP_F2: inner_ff <= ONE10_M - prod_hi;
         OP_F5: fade_ff[cmd.axis] <= prod_hi[FRAC_BITS:0];
         OP_H1, OP_H2, OP_H3: hash_ff <= PERM_TABLE[hidx];
         OP_GRAD: val_ff[cmd.corner] <= grad;
         OP_L2: val_ff[ldst] <= lsum[GW-1:0];
         OP_ACC_MUL: prod2_ff <= pw * $signed({1'b0, amp_ff});
         OP_ACC_ADD: begin
            total_ff  <= total_ff + TW'(prod2_ff);
            ampsum_ff <= ampsum_ff + AW'(amp_ff);
            ampm_ff   <= amp_ff * persistence;
         end
         OP_AMP: begin
            amp_ff <= (|amp_sh[33:32]) ? 32'hFFFF_FFFF : amp_sh[31:0];
            // next octave: double, integer part wraps
            cx_ff  <= {cx_ff[CW-2:0], 1'b0};
            cy_ff  <= {cy_ff[CW-2:0], 1'b0};
            cz_ff  <= {cz_ff[CW-2:0], 1'b0};
         end
         OP_DIV_INIT: begin
            rem_ff <= '0;
            quo_ff <= total_ff;
         end
         // restoring division, one quotient bit per cycle
         OP_DIV_STEP: begin
            if (remt >= {1'b0, ampsum_ff}) begin
               rem_ff <= remt - {1'b0, ampsum_ff};
               quo_ff <= {quo_ff[TW-2:0], 1'b1};
            end else begin
               rem_ff <= remt;
               quo_ff <= {quo_ff[TW-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   // Scale quotient to Q0.16, saturate, clamp non-positive totals to zero
   always_comb begin
      qw = (TW + 16)'(quo_ff);
      qs = (qw >> SHR) << SHL;
      status.total_pos = (total_ff > 0);
      if (!status.total_pos) begin
         noise_value = 16'd0;
      end else if (|qs[TW+15:16]) begin
         noise_value = 16'hFFFF;
      end else begin
         noise_value = qs[15:0];
      end
   end

endmodule

@@ hdl/octave_gradient_noise_3d.sv @@
// Octave gradient noise: each item is a point (x, y, z) in unsigned Q8.FRAC_BITS; the result
// is the amplitude-weighted mean of improved gradient noise over octave_count octaves
// (coordinates doubled per octave, amplitude scaled by persistence in Q2.14), as Q0.16
// saturated at 65535. One item is in work at a time. Each octave runs fade,
// hash/gradient, interpolation and accumulate steps, set by the one shared multiplier
// and the single permutation ROM read per cycle; then the mean is found by bit-serial
// division when the total is positive, and the result is handed over once the output
// register is free. The result waits in an output register, so the next item is taken
// while it is still unread.
module octave_gradient_noise_3d #(
   parameter int FRAC_BITS   = 16,
   parameter int MAX_OCTAVES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // coord_x [23:0], coord_y [47:24], coord_z [71:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // noise_value [15:0]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import ogn3d_pkg::*;

   localparam int TOTAL_W = FRAC_BITS + 36 + $clog2(MAX_OCTAVES);

   logic [3:0]  octave_count_ff;
   logic [15:0] persistence_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic        out_free;
   logic [15:0] noise_value;
   cmd_type     cmd;
   status_type  status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= 4'd1;
         persistence_ff  <= 16'd16384;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_wdata[3:0];
            default:          persistence_ff  <= csr_wdata;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   ogn3d_ctrl #(
      .MAX_OCTAVES (MAX_OCTAVES),
      .DIV_STEPS   (TOTAL_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .out_free     (out_free),
      .octave_count (octave_count_ff),
      .status       (status),
      .cmd          (cmd)
   );

   ogn3d_dp #(
      .FRAC_BITS   (FRAC_BITS),
      .MAX_OCTAVES (MAX_OCTAVES),
      .TOTAL_W     (TOTAL_W)
   ) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .coord_x     (req_tdata[23:0]),
      .coord_y     (req_tdata[47:24]),
      .coord_z     (req_tdata[71:48]),
      .persistence (persistence_ff),
      .status      (status),
      .noise_value (noise_value)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_DONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DONE) begin
         rsp_data_ff <= noise_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/ogn3d_chk.sv @@
`include "octave_gradient_noise_3d_assert.svh"

module ogn3d_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Output handshake holds while stalled
   `OGN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped")
   `OGN_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp data changed")
   // One item in work: busy right after an accept, and no instant result
   `OGN_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "accepted while busy")
   `OGN_ASSERT_NEXT(a_no_instant, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid), "result too early")
   // Reset empties the output
   `OGN_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "rsp valid after reset")

endmodule

bind octave_gradient_noise_3d ogn3d_chk u_ogn3d_chk (.*);

@@ tb/tb_octave_gradient_noise_3d.sv @@
`timescale 1ns / 100ps

module tb_octave_gradient_noise_3d;
   import ogn3d_pkg::*;

   localparam int FRAC = 16;
   localparam longint ONE = 64'sd1 << FRAC;
   localparam logic [23:0] CMASK = 24'hFFFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_OCTAVE_COUNT;
   logic [15:0] csr_wdata = '0;

   // stimulus and expected noise values
   logic [71:0] point_q[$];
   logic [15:0] noise_q[$];
   int errors = 0;
   int n_sent = 0;
   int n_got = 0;
   bit quiet = 1'b0;     // no idling in the last part
   int hold_cycles = 0;  // long receiver hold-off
   int gap = 0;
   int stall = 0;

   // predictor's own copy of the registers
   logic [3:0]  oct_reg = 4'd1;
   logic [15:0] pers_reg = 16'd16384;

   octave_gradient_noise_3d DUT (.*);

   always #4 clock = ~clock;

   // floor division by 2^s
   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint fade(longint f);
      longint inner, s;
      inner = 10 * ONE - ((f * (15 * ONE - 6 * f)) >>> FRAC);
      s = (f * f) >>> FRAC;
      s = (s * f) >>> FRAC;
      return (s * inner) >>> FRAC;
   endfunction

   function automatic longint grad(int h, longint x, longint y, longint z);
      case (h & 15)
         0: return x + y;
         1: return -x + y;
         2: return x - y;
         3: return -x - y;
         4: return x + z;
         5: return -x + z;
         6: return x - z;
         7: return -x - z;
         8: return y + z;
         9: return -y + z;
         10: return y - z;
         11: return -y - z;
         12: return y + x;
         13: return -y + z;
         14: return y - x;
         default: return -y - z;
      endcase
   endfunction

   function automatic longint mix(longint a, longint b, longint u);
      return a + fshr(u * (b - a), FRAC);
   endfunction

   function automatic int corner_hash(int xi, int yi, int zi);
      int h;
      h = PERM_TABLE[xi & 255];
      h = PERM_TABLE[(h + yi) & 255];
      return PERM_TABLE[(h + zi) & 255];
   endfunction

   function automatic longint gradient_noise(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
      int xi, yi, zi, xj, yj, zj;
      longint xf, yf, zf, xg, yg, zg, u, v, w, a, b, y1, y2;
      xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
      xj = (xi + 1) & 255; yj = (yi + 1) & 255; zj = (zi + 1) & 255;
      xf = cx[15:0]; yf = cy[15:0]; zf = cz[15:0];
      xg = xf - ONE; yg = yf - ONE; zg = zf - ONE;
      u = fade(xf); v = fade(yf); w = fade(zf);
      a = mix(grad(corner_hash(xi, yi, zi), xf, yf, zf),
              grad(corner_hash(xj, yi, zi), xg, yf, zf), u);
      b = mix(grad(corner_hash(xi, yj, zi), xf, yg, zf),
              grad(corner_hash(xj, yj, zi), xg, yg, zf), u);
      y1 = mix(a, b, v);
      a = mix(grad(corner_hash(xi, yi, zj), xf, yf, zg),
              grad(corner_hash(xj, yi, zj), xg, yf, zg), u);
      b = mix(grad(corner_hash(xi, yj, zj), xf, yg, zg),
              grad(corner_hash(xj, yj, zj), xg, yg, zg), u);
      y2 = mix(a, b, v);
      return mix(y1, y2, w);
   endfunction

   function automatic logic [15:0] octave_noise(logic [71:0] pt);
      int noct;
      longint amp, ampsum, total, n, p, q;
      logic [23:0] cx, cy, cz;
      noct = (oct_reg == 0) ? 1 : (oct_reg > 8 ? 8 : oct_reg);
      amp = 16384; ampsum = 0; total = 0;
      for (int i = 0; i < noct; i++) begin
         cx = pt[23:0] << i; cy = pt[47:24] << i; cz = pt[71:48] << i;
         n = gradient_noise(cx & CMASK, cy & CMASK, cz & CMASK);
         p = fshr(n + ONE, 1);
         total += p * amp;
         ampsum += amp;
         amp = (amp * pers_reg) >> 14;
         if (amp > 64'hFFFFFFFF) amp = 64'hFFFFFFFF;
      end
      if (total <= 0) return 16'd0;
      q = total / ampsum;
      if (q > 65535) return 16'hFFFF;
      return q[15:0];
   endfunction

   // driver: predicts at acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            noise_q.push_back(octave_noise(req_tdata));
            n_sent <= n_sent + 1;
         end
         if ((req_tvalid && !req_tready) || (req_tvalid && req_tready && 0)) begin
            // hold current item
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_tvalid <= 1'b0;
         end else if (point_q.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata <= point_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
            if (!quiet && point_q.size() > 0) gap <= $urandom_range(0, 3);
         end
      end
   end

   // monitor and receiver idling
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_got <= n_got + 1;
            if (noise_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d", $time, rsp_tdata);
               errors++;
            end else begin
               if (rsp_tdata !== noise_q[0]) begin
                  $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                           $time, noise_q[0], rsp_tdata);
                  errors++;
               end
               void'(noise_q.pop_front());
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall <= $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic add_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
      point_q.push_back({z, y, x});
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'h0;
         1: return 24'hFFFFFF;
         2: return {8'($urandom_range(0, 255)), 16'h0};
         default: return 24'($urandom()) & CMASK;
      endcase
   endfunction

   task automatic drain();
      wait (point_q.size() == 0 && !req_tvalid);
      wait (noise_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_OCTAVE_COUNT) oct_reg = val[3:0];
      else pers_reg = val;
   endtask

   initial begin
      int settings[8][2] = '{'{1, 16384}, '{8, 16384}, '{0, 0}, '{15, 65535},
                             '{3, 32768}, '{9, 1}, '{5, 49152}, '{2, 20000}};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes and wrap cases at reset settings
      add_point(24'h0, 24'h0, 24'h0);
      add_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      add_point(24'h010000, 24'h020000, 24'h030000);
      add_point(24'h008000, 24'h008000, 24'h008000);
      add_point(24'hFF8000, 24'h00FFFF, 24'h7F0001);
      add_point(24'hAAAAAA, 24'h555555, 24'h0);
      for (int i = 0; i < 10; i++) add_point(rand_coord(), rand_coord(), rand_coord());
      drain();
      // random phases over register settings; long hold-off in the second
      for (int s = 0; s < 8; s++) begin
         if (s == 0 || $urandom_range(0, 1))
            csr_write(CSR_OCTAVE_COUNT, 16'(settings[s][0]));
         if (s == 0 || $urandom_range(0, 1))
            csr_write(CSR_PERSISTENCE, 16'(settings[s][1]));
         if (s == 1) hold_cycles = 3000;
         if (s == 7) quiet = 1'b1;
         for (int i = 0; i < 115; i++) add_point(rand_coord(), rand_coord(), rand_coord());
         drain();
      end
      $display("Covered %0d items over eight register settings incl. octave 0/15 and", n_sent);
      $display("persistence extremes, with input and output stalls; %0d results.", n_got);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(1000 * 8 * 2000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
